// ----- rtl/vaq_pkg.sv -----
// ============================================================================
// vaq_pkg
// Shared constants for the ventilation alarm qualifier: register indexes,
// port widths, reset values and item command codes.
// ============================================================================
package vaq_pkg;

    // Configuration port widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESSURE_HIGH_LIMIT      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESSURE_LOW_LIMIT       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_HIGH_LIMIT        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_LOW_LIMIT         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_PRESSURE_CONFIRM_MS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_PRESSURE_BREATHS     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_CONFIRM_BREATHS   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMMEDIATE_RATIO_Q8       = 3'd7;

    // Register reset values
    localparam logic [10:0] RST_PRESSURE_HIGH_LIMIT      = 11'd400;
    localparam logic [10:0] RST_PRESSURE_LOW_LIMIT       = 11'd50;
    localparam logic [11:0] RST_VOLUME_HIGH_LIMIT        = 12'd1000;
    localparam logic [11:0] RST_VOLUME_LOW_LIMIT         = 12'd200;
    localparam logic [15:0] RST_HIGH_PRESSURE_CONFIRM_MS = 16'd100;
    localparam logic [3:0]  RST_LOW_PRESSURE_BREATHS     = 4'd3;
    localparam logic [3:0]  RST_VOLUME_CONFIRM_BREATHS   = 4'd3;
    localparam logic [9:0]  RST_IMMEDIATE_RATIO_Q8       = 10'd384;

    // Item command codes
    localparam logic CMD_PRESSURE = 1'b0;
    localparam logic CMD_BREATH   = 1'b1;

endpackage

// ----- rtl/ventilation_alarm_qualifier_unit.sv -----
// ============================================================================
// ventilation_alarm_qualifier_unit
// Qualifies high pressure, low pressure, high volume and low volume alarms
// from pressure samples and breath results.
// ============================================================================
// Path: an item passes the input register, then the result register, and
//   waits in the input register while the result side stalls.
// Throughput: 1 item per cycle while the result side does not stall; the
//   alarm update sits between the input register and the result register.
// Reset: rst_n clears all alarm state, counters and sequence tracking and
//   loads the configuration defaults; no clearing pass is needed.
module ventilation_alarm_qualifier_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vaq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vaq_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input item channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cmd,
    input  logic [31:0]                      now_ms,
    input  logic                             expiring,
    input  logic signed [11:0]               airway_pressure,
    input  logic [31:0]                      breath_seq,
    input  logic                             breath_complete,
    input  logic                             peak_valid,
    input  logic                             plateau_valid,
    input  logic                             volume_valid,
    input  logic signed [11:0]               peak_pressure,
    input  logic signed [11:0]               plateau_pressure,
    input  logic [15:0]                      exhaled_volume,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             high_pressure_alarm,
    output logic                             low_pressure_alarm,
    output logic                             high_volume_alarm,
    output logic                             low_volume_alarm
);
    import vaq_pkg::*;

    // configuration registers
    logic [10:0] pressure_high_limit_reg;
    logic [10:0] pressure_low_limit_reg;
    logic [11:0] volume_high_limit_reg;
    logic [11:0] volume_low_limit_reg;
    logic [15:0] high_pressure_confirm_ms_reg;
    logic [3:0]  low_pressure_breaths_reg;
    logic [3:0]  volume_confirm_breaths_reg;
    logic [9:0]  immediate_ratio_q8_reg;

    // input register
    logic               s1_valid_reg;
    logic               s1_cmd_reg;
    logic [31:0]        s1_now_ms_reg;
    logic               s1_expiring_reg;
    logic signed [11:0] s1_airway_pressure_reg;
    logic [31:0]        s1_breath_seq_reg;
    logic               s1_breath_complete_reg;
    logic               s1_peak_valid_reg;
    logic               s1_plateau_valid_reg;
    logic               s1_volume_valid_reg;
    logic signed [11:0] s1_peak_pressure_reg;
    logic signed [11:0] s1_plateau_pressure_reg;
    logic [15:0]        s1_exhaled_volume_reg;

    // alarm state
    logic        pressure_timing_reg,      pressure_timing_next;
    logic [31:0] pressure_start_ms_reg,    pressure_start_ms_next;
    logic        high_pressure_active_reg, high_pressure_active_next;
    logic        seq_seen_reg,             seq_seen_next;
    logic [31:0] last_seq_reg,             last_seq_next;
    logic [3:0]  low_pressure_count_reg,   low_pressure_count_next;
    logic        low_pressure_active_reg,  low_pressure_active_next;
    logic [3:0]  high_volume_count_reg,    high_volume_count_next;
    logic        high_volume_active_reg,   high_volume_active_next;
    logic [3:0]  low_volume_count_reg,     low_volume_count_next;
    logic        low_volume_active_reg,    low_volume_active_next;

    // result register
    logic out_valid_reg;
    logic out_hp_reg;
    logic out_lp_reg;
    logic out_hv_reg;
    logic out_lv_reg;

    logic advance;

    // datapath terms
    logic signed [11:0] hi_p_lim;
    logic signed [11:0] lo_p_lim;
    logic [31:0]        elapsed_ms;
    logic [15:0]        hi_v_lim;
    logic [15:0]        lo_v_lim;
    logic [25:0]        imm_v_lim;
    logic [25:0]        vol_x256;
    logic               p_low;
    logic               p_rec;

    // Saturating consecutive-breath counter step
    function automatic logic [3:0] count_step(input logic [3:0] count, input logic [3:0] need);
        logic [3:0] c;
        c = count;
        if (c < need)
        begin
            c = c + 4'd1;
        end
        return c;
    endfunction

    // Handshake: move item forward when the result register is free
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid           = out_valid_reg;
    assign high_pressure_alarm = out_hp_reg;
    assign low_pressure_alarm  = out_lp_reg;
    assign high_volume_alarm   = out_hv_reg;
    assign low_volume_alarm    = out_lv_reg;

    // Scale limits: pressures as signed, volumes to 0.1 mL (x10 by shift-add)
    assign hi_p_lim   = $signed({1'b0, pressure_high_limit_reg});
    assign lo_p_lim   = $signed({1'b0, pressure_low_limit_reg});
    assign elapsed_ms = s1_now_ms_reg - pressure_start_ms_reg;
    assign hi_v_lim   = {1'b0, volume_high_limit_reg, 3'b000}
                      + {3'b000, volume_high_limit_reg, 1'b0};
    assign lo_v_lim   = {1'b0, volume_low_limit_reg, 3'b000}
                      + {3'b000, volume_low_limit_reg, 1'b0};
    assign imm_v_lim  = 26'(immediate_ratio_q8_reg) * 26'(hi_v_lim);
    assign vol_x256   = {2'b00, s1_exhaled_volume_reg, 8'h00};

    // Low pressure and recovery flags from peak and plateau
    assign p_low = (s1_peak_valid_reg && (s1_peak_pressure_reg < lo_p_lim))
                || (s1_plateau_valid_reg && (s1_plateau_pressure_reg < lo_p_lim));
    assign p_rec = (s1_peak_valid_reg && (s1_peak_pressure_reg > lo_p_lim))
                || (s1_plateau_valid_reg && (s1_plateau_pressure_reg > lo_p_lim));

    // Update alarm state for the item leaving the input register
    always_comb
    begin
        pressure_timing_next      = pressure_timing_reg;
        pressure_start_ms_next    = pressure_start_ms_reg;
        high_pressure_active_next = high_pressure_active_reg;
        seq_seen_next             = seq_seen_reg;
        last_seq_next             = last_seq_reg;
        low_pressure_count_next   = low_pressure_count_reg;
        low_pressure_active_next  = low_pressure_active_reg;
        high_volume_count_next    = high_volume_count_reg;
        high_volume_active_next   = high_volume_active_reg;
        low_volume_count_next     = low_volume_count_reg;
        low_volume_active_next    = low_volume_active_reg;

        if (advance)
        begin
            if (s1_cmd_reg == CMD_PRESSURE)
            begin
                // high pressure: time the excursion, clear in expiration
                if (s1_expiring_reg)
                begin
                    pressure_timing_next      = 1'b0;
                    high_pressure_active_next = 1'b0;
                end
                else if (!(s1_airway_pressure_reg > hi_p_lim))
                begin
                    pressure_timing_next = 1'b0;
                end
                else if (!pressure_timing_reg)
                begin
                    pressure_start_ms_next = s1_now_ms_reg;
                    pressure_timing_next   = 1'b1;
                end
                else if (elapsed_ms >= {16'h0000, high_pressure_confirm_ms_reg})
                begin
                    high_pressure_active_next = 1'b1;
                end
            end
            else if (s1_breath_complete_reg
                     && !(seq_seen_reg && (last_seq_reg == s1_breath_seq_reg)))
            begin
                last_seq_next = s1_breath_seq_reg;
                seq_seen_next = 1'b1;

                // low pressure: recovery wins over a low value
                if (p_rec)
                begin
                    low_pressure_count_next  = 4'd0;
                    low_pressure_active_next = 1'b0;
                end
                else if (p_low)
                begin
                    low_pressure_count_next = count_step(low_pressure_count_reg,
                                                         low_pressure_breaths_reg);
                    if (low_pressure_count_next >= low_pressure_breaths_reg)
                    begin
                        low_pressure_active_next = 1'b1;
                    end
                end
                else
                begin
                    low_pressure_count_next = 4'd0;
                end

                if (!s1_volume_valid_reg)
                begin
                    high_volume_count_next = 4'd0;
                    low_volume_count_next  = 4'd0;
                end
                else
                begin
                    // high volume: immediate above ratio times limit
                    if (s1_exhaled_volume_reg < hi_v_lim)
                    begin
                        high_volume_count_next  = 4'd0;
                        high_volume_active_next = 1'b0;
                    end
                    else if (vol_x256 > imm_v_lim)
                    begin
                        high_volume_count_next  = volume_confirm_breaths_reg;
                        high_volume_active_next = 1'b1;
                    end
                    else if (s1_exhaled_volume_reg > hi_v_lim)
                    begin
                        high_volume_count_next = count_step(high_volume_count_reg,
                                                            volume_confirm_breaths_reg);
                        if (high_volume_count_next >= volume_confirm_breaths_reg)
                        begin
                            high_volume_active_next = 1'b1;
                        end
                    end
                    else
                    begin
                        high_volume_count_next = 4'd0;
                    end

                    // low volume
                    if (s1_exhaled_volume_reg > lo_v_lim)
                    begin
                        low_volume_count_next  = 4'd0;
                        low_volume_active_next = 1'b0;
                    end
                    else if (s1_exhaled_volume_reg < lo_v_lim)
                    begin
                        low_volume_count_next = count_step(low_volume_count_reg,
                                                           volume_confirm_breaths_reg);
                        if (low_volume_count_next >= volume_confirm_breaths_reg)
                        begin
                            low_volume_active_next = 1'b1;
                        end
                    end
                    else
                    begin
                        low_volume_count_next = 4'd0;
                    end
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressure_high_limit_reg      <= RST_PRESSURE_HIGH_LIMIT;
            pressure_low_limit_reg       <= RST_PRESSURE_LOW_LIMIT;
            volume_high_limit_reg        <= RST_VOLUME_HIGH_LIMIT;
            volume_low_limit_reg         <= RST_VOLUME_LOW_LIMIT;
            high_pressure_confirm_ms_reg <= RST_HIGH_PRESSURE_CONFIRM_MS;
            low_pressure_breaths_reg     <= RST_LOW_PRESSURE_BREATHS;
            volume_confirm_breaths_reg   <= RST_VOLUME_CONFIRM_BREATHS;
            immediate_ratio_q8_reg       <= RST_IMMEDIATE_RATIO_Q8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PRESSURE_HIGH_LIMIT:      pressure_high_limit_reg      <= cfg_data[10:0];
                CFG_PRESSURE_LOW_LIMIT:       pressure_low_limit_reg       <= cfg_data[10:0];
                CFG_VOLUME_HIGH_LIMIT:        volume_high_limit_reg        <= cfg_data[11:0];
                CFG_VOLUME_LOW_LIMIT:         volume_low_limit_reg         <= cfg_data[11:0];
                CFG_HIGH_PRESSURE_CONFIRM_MS: high_pressure_confirm_ms_reg <= cfg_data;
                CFG_LOW_PRESSURE_BREATHS:     low_pressure_breaths_reg     <= cfg_data[3:0];
                CFG_VOLUME_CONFIRM_BREATHS:   volume_confirm_breaths_reg   <= cfg_data[3:0];
                CFG_IMMEDIATE_RATIO_Q8:       immediate_ratio_q8_reg       <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg              <= cmd;
            s1_now_ms_reg           <= now_ms;
            s1_expiring_reg         <= expiring;
            s1_airway_pressure_reg  <= airway_pressure;
            s1_breath_seq_reg       <= breath_seq;
            s1_breath_complete_reg  <= breath_complete;
            s1_peak_valid_reg       <= peak_valid;
            s1_plateau_valid_reg    <= plateau_valid;
            s1_volume_valid_reg     <= volume_valid;
            s1_peak_pressure_reg    <= peak_pressure;
            s1_plateau_pressure_reg <= plateau_pressure;
            s1_exhaled_volume_reg   <= exhaled_volume;
        end
    end

    // Alarm state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressure_timing_reg      <= 1'b0;
            pressure_start_ms_reg    <= 32'd0;
            high_pressure_active_reg <= 1'b0;
            seq_seen_reg             <= 1'b0;
            last_seq_reg             <= 32'd0;
            low_pressure_count_reg   <= 4'd0;
            low_pressure_active_reg  <= 1'b0;
            high_volume_count_reg    <= 4'd0;
            high_volume_active_reg   <= 1'b0;
            low_volume_count_reg     <= 4'd0;
            low_volume_active_reg    <= 1'b0;
        end
        else
        begin
            pressure_timing_reg      <= pressure_timing_next;
            pressure_start_ms_reg    <= pressure_start_ms_next;
            high_pressure_active_reg <= high_pressure_active_next;
            seq_seen_reg             <= seq_seen_next;
            last_seq_reg             <= last_seq_next;
            low_pressure_count_reg   <= low_pressure_count_next;
            low_pressure_active_reg  <= low_pressure_active_next;
            high_volume_count_reg    <= high_volume_count_next;
            high_volume_active_reg   <= high_volume_active_next;
            low_volume_count_reg     <= low_volume_count_next;
            low_volume_active_reg    <= low_volume_active_next;
        end
    end

    // Result register control: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload: alarm states after this item
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_hp_reg <= high_pressure_active_next;
            out_lp_reg <= low_pressure_active_next;
            out_hv_reg <= high_volume_active_next;
            out_lv_reg <= low_volume_active_next;
        end
    end

endmodule

// ----- rtl/vaq_checker.sv -----
// ============================================================================
// vaq_checker
// Port-level checks on the ventilation alarm qualifier: result holding,
// backpressure, input-to-result timing and expiration clearing.
// ============================================================================
module vaq_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic cmd,
    input logic expiring,
    input logic out_valid,
    input logic out_ready,
    input logic high_pressure_alarm,
    input logic low_pressure_alarm,
    input logic high_volume_alarm,
    input logic low_volume_alarm
);
    import vaq_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({high_pressure_alarm, low_pressure_alarm,
                        high_volume_alarm, low_volume_alarm}))
        else $error("stalled result changed");

    // Input side stalls only behind a stalled result
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // A new result follows an input transaction through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching input transaction");

    // A pressure sample in expiration clears the high pressure alarm
    a_exp_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (cmd == CMD_PRESSURE) && expiring)
            ##1 (!out_valid || out_ready)
        |=> out_valid && !high_pressure_alarm)
        else $error("high pressure alarm not cleared in expiration");

endmodule

bind ventilation_alarm_qualifier_unit vaq_checker u_vaq_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .cmd                 (cmd),
    .expiring            (expiring),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .high_pressure_alarm (high_pressure_alarm),
    .low_pressure_alarm  (low_pressure_alarm),
    .high_volume_alarm   (high_volume_alarm),
    .low_volume_alarm    (low_volume_alarm)
);

// ----- sim/tb.sv -----
// ============================================================================
// tb
// Self-checking testbench for the ventilation alarm qualifier. It runs a short
// directed sequence (confirm timing, time wrap, rejected and repeated
// breaths, count thresholds, recovery and equal-to-limit cases), then random
// pressure and breath traffic under several register settings. A local
// alarm predictor tracks every accepted transaction, and the monitor checks
// each result against it while both sides idle and stall at random.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vaq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic               cmd;
        logic [31:0]        now_ms;
        logic               expiring;
        logic signed [11:0] airway_pressure;
        logic [31:0]        breath_seq;
        logic               breath_complete;
        logic               peak_valid;
        logic               plateau_valid;
        logic               volume_valid;
        logic signed [11:0] peak_pressure;
        logic signed [11:0] plateau_pressure;
        logic [15:0]        exhaled_volume;
    } vent_item_t;

    // bit 3 high pressure, 2 low pressure, 1 high volume, 0 low volume
    typedef logic [3:0] alarm_vec_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               cmd = 1'b0;
    logic [31:0]        now_ms = '0;
    logic               expiring = 1'b0;
    logic signed [11:0] airway_pressure = '0;
    logic [31:0]        breath_seq = '0;
    logic               breath_complete = 1'b0;
    logic               peak_valid = 1'b0;
    logic               plateau_valid = 1'b0;
    logic               volume_valid = 1'b0;
    logic signed [11:0] peak_pressure = '0;
    logic signed [11:0] plateau_pressure = '0;
    logic [15:0]        exhaled_volume = '0;

    logic out_valid;
    logic out_ready = 1'b0;
    logic high_pressure_alarm;
    logic low_pressure_alarm;
    logic high_volume_alarm;
    logic low_volume_alarm;

    ventilation_alarm_qualifier_unit u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .cmd                 (cmd),
        .now_ms              (now_ms),
        .expiring            (expiring),
        .airway_pressure     (airway_pressure),
        .breath_seq          (breath_seq),
        .breath_complete     (breath_complete),
        .peak_valid          (peak_valid),
        .plateau_valid       (plateau_valid),
        .volume_valid        (volume_valid),
        .peak_pressure       (peak_pressure),
        .plateau_pressure    (plateau_pressure),
        .exhaled_volume      (exhaled_volume),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .high_pressure_alarm (high_pressure_alarm),
        .low_pressure_alarm  (low_pressure_alarm),
        .high_volume_alarm   (high_volume_alarm),
        .low_volume_alarm    (low_volume_alarm)
    );

    // ------------------------------------------------------------------------
    // Predictor copy of the registers and alarm state
    // ------------------------------------------------------------------------
    logic [10:0] lim_p_hi   = RST_PRESSURE_HIGH_LIMIT;
    logic [10:0] lim_p_lo   = RST_PRESSURE_LOW_LIMIT;
    logic [11:0] lim_v_hi   = RST_VOLUME_HIGH_LIMIT;
    logic [11:0] lim_v_lo   = RST_VOLUME_LOW_LIMIT;
    logic [15:0] confirm_ms = RST_HIGH_PRESSURE_CONFIRM_MS;
    logic [3:0]  lp_need    = RST_LOW_PRESSURE_BREATHS;
    logic [3:0]  vol_need   = RST_VOLUME_CONFIRM_BREATHS;
    logic [9:0]  ratio_q8   = RST_IMMEDIATE_RATIO_Q8;

    bit          hp_timing = 1'b0;
    logic [31:0] hp_start  = '0;
    bit          hp_active = 1'b0;
    bit          seq_seen  = 1'b0;
    logic [31:0] last_seq  = '0;
    logic [3:0]  lp_count  = '0;
    bit          lp_active = 1'b0;
    logic [3:0]  hv_count  = '0;
    bit          hv_active = 1'b0;
    logic [3:0]  lv_count  = '0;
    bit          lv_active = 1'b0;

    vent_item_t item_backlog[$];
    alarm_vec_t alarm_due[$];
    vent_item_t on_wire;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    bit          quiet_send = 1'b0;
    bit          quiet_recv = 1'b0;
    int unsigned errors = 0;
    int unsigned cycles = 0;
    logic [31:0] gen_ms = '0;
    logic [31:0] gen_seq = '0;
    string       alarm_name[4] = '{"low_volume", "high_volume", "low_pressure",
                                   "high_pressure"};

    // Advance a consecutive-breath count, saturating at the threshold
    function automatic logic [3:0] bump(input logic [3:0] c, input logic [3:0] need);
        return (c < need) ? c + 4'd1 : c;
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_PRESSURE_HIGH_LIMIT:      lim_p_hi   = val[10:0];
            CFG_PRESSURE_LOW_LIMIT:       lim_p_lo   = val[10:0];
            CFG_VOLUME_HIGH_LIMIT:        lim_v_hi   = val[11:0];
            CFG_VOLUME_LOW_LIMIT:         lim_v_lo   = val[11:0];
            CFG_HIGH_PRESSURE_CONFIRM_MS: confirm_ms = val;
            CFG_LOW_PRESSURE_BREATHS:     lp_need    = val[3:0];
            CFG_VOLUME_CONFIRM_BREATHS:   vol_need   = val[3:0];
            CFG_IMMEDIATE_RATIO_Q8:       ratio_q8   = val[9:0];
            default: ;
        endcase
    endfunction

    // Update the alarm state for one transaction and return the alarm set
    function automatic alarm_vec_t advance_alarms(input vent_item_t it);
        int     hi_lim;
        int     lo_lim;
        int     pr;
        int     pk;
        int     pl;
        longint vol;
        longint vlim;
        longint ratio;
        logic [31:0] elapsed;
        bit     low;
        bit     recovered;
        hi_lim = int'(lim_p_hi);
        lo_lim = int'(lim_p_lo);
        pr     = int'(it.airway_pressure);
        pk     = int'(it.peak_pressure);
        pl     = int'(it.plateau_pressure);
        vol    = longint'(it.exhaled_volume);
        ratio  = longint'(ratio_q8);
        if (it.cmd == CMD_PRESSURE)
        begin
            // expiration clears, below limit drops timing, first high starts it
            if (it.expiring)
            begin
                hp_timing = 1'b0;
                hp_active = 1'b0;
            end
            else if (!(pr > hi_lim))
            begin
                hp_timing = 1'b0;
            end
            else if (!hp_timing)
            begin
                hp_start  = it.now_ms;
                hp_timing = 1'b1;
            end
            else
            begin
                elapsed = it.now_ms - hp_start;
                if (elapsed >= {16'd0, confirm_ms})
                    hp_active = 1'b1;
            end
        end
        else if (it.breath_complete && !(seq_seen && last_seq == it.breath_seq))
        begin
            last_seq = it.breath_seq;
            seq_seen = 1'b1;

            // low pressure: recovery on either valid value wins
            low       = (it.peak_valid && pk < lo_lim) || (it.plateau_valid && pl < lo_lim);
            recovered = (it.peak_valid && pk > lo_lim) || (it.plateau_valid && pl > lo_lim);
            if (recovered)
            begin
                lp_count  = '0;
                lp_active = 1'b0;
            end
            else if (low)
            begin
                lp_count = bump(lp_count, lp_need);
                if (lp_count >= lp_need)
                    lp_active = 1'b1;
            end
            else
            begin
                lp_count = '0;
            end

            if (!it.volume_valid)
            begin
                hv_count = '0;
                lv_count = '0;
            end
            else
            begin
                // high volume, compared in 0.1 mL; immediate scaled by 256
                vlim = longint'(lim_v_hi);
                vlim = vlim * 10;
                if (vol < vlim)
                begin
                    hv_count  = '0;
                    hv_active = 1'b0;
                end
                else if (vol * 256 > ratio * vlim)
                begin
                    hv_count  = vol_need;
                    hv_active = 1'b1;
                end
                else if (vol > vlim)
                begin
                    hv_count = bump(hv_count, vol_need);
                    if (hv_count >= vol_need)
                        hv_active = 1'b1;
                end
                else
                begin
                    hv_count = '0;
                end

                // low volume
                vlim = longint'(lim_v_lo);
                vlim = vlim * 10;
                if (vol > vlim)
                begin
                    lv_count  = '0;
                    lv_active = 1'b0;
                end
                else if (vol < vlim)
                begin
                    lv_count = bump(lv_count, vol_need);
                    if (lv_count >= vol_need)
                        lv_active = 1'b1;
                end
                else
                begin
                    lv_count = '0;
                end
            end
        end
        return {hp_active, lp_active, hv_active, lv_active};
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [11:0] clip_p(input int v);
        if (v > 2047)
            return 12'sh7FF;
        else if (v < -2048)
            return 12'sh800;
        else
            return v[11:0];
    endfunction

    function automatic logic [15:0] clip_v(input int v);
        if (v > 65535)
            return 16'hFFFF;
        else if (v < 0)
            return 16'h0000;
        else
            return v[15:0];
    endfunction

    function automatic int near(input int center, input int span);
        int d;
        d = int'($urandom_range(0, 2 * span));
        return center + d - span;
    endfunction

    // Random content everywhere, so unused fields toggle as well
    function automatic vent_item_t noise_item();
        vent_item_t it;
        it.cmd              = 1'($urandom_range(0, 1));
        it.now_ms           = $urandom;
        it.expiring         = 1'($urandom_range(0, 1));
        it.airway_pressure  = 12'($urandom);
        it.breath_seq       = $urandom;
        it.breath_complete  = 1'($urandom_range(0, 1));
        it.peak_valid       = 1'($urandom_range(0, 1));
        it.plateau_valid    = 1'($urandom_range(0, 1));
        it.volume_valid     = 1'($urandom_range(0, 1));
        it.peak_pressure    = 12'($urandom);
        it.plateau_pressure = 12'($urandom);
        it.exhaled_volume   = 16'($urandom);
        return it;
    endfunction

    function automatic vent_item_t make_sample(input logic [31:0] t, input logic ph,
                                               input int p);
        vent_item_t it;
        it                 = noise_item();
        it.cmd             = CMD_PRESSURE;
        it.now_ms          = t;
        it.expiring        = ph;
        it.airway_pressure = clip_p(p);
        return it;
    endfunction

    function automatic vent_item_t make_breath(input logic [31:0] seq, input int done,
                                               input int pkv, input int plv,
                                               input int vv, input int pk, input int pl,
                                               input int vol);
        vent_item_t it;
        it                  = noise_item();
        it.cmd              = CMD_BREATH;
        it.breath_seq       = seq;
        it.breath_complete  = done[0];
        it.peak_valid       = pkv[0];
        it.plateau_valid    = plv[0];
        it.volume_valid     = vv[0];
        it.peak_pressure    = clip_p(pk);
        it.plateau_pressure = clip_p(pl);
        it.exhaled_volume   = clip_v(vol);
        return it;
    endfunction

    // Mostly well-formed traffic around the current limits
    function automatic vent_item_t random_item();
        vent_item_t it;
        int unsigned r;
        int a;
        int b;
        it = noise_item();
        if ($urandom_range(0, 1) == 0)
        begin
            it.cmd = CMD_PRESSURE;
            r = $urandom_range(0, 99);
            if (r < 5)
                gen_ms = $urandom;
            else
                gen_ms = gen_ms + $urandom_range(0, confirm_ms / 3 + 3);
            it.now_ms   = gen_ms;
            it.expiring = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 70)
                it.airway_pressure = clip_p(near(int'(lim_p_hi), 20));
            else if (r < 85)
                it.airway_pressure = clip_p(int'(lim_p_hi) + int'($urandom_range(1, 300)));
        end
        else
        begin
            it.cmd = CMD_BREATH;
            r = $urandom_range(0, 99);
            if (r < 80)
                gen_seq = gen_seq + 32'd1;
            else if (r >= 92)
                gen_seq = $urandom;
            it.breath_seq      = gen_seq;
            it.breath_complete = ($urandom_range(0, 9) != 0);
            it.peak_valid      = ($urandom_range(0, 6) != 0);
            it.plateau_valid   = ($urandom_range(0, 6) != 0);
            it.volume_valid    = ($urandom_range(0, 6) != 0);
            if ($urandom_range(0, 9) != 0)
                it.peak_pressure = clip_p(near(int'(lim_p_lo), 15));
            if ($urandom_range(0, 9) != 0)
                it.plateau_pressure = clip_p(near(int'(lim_p_lo), 15));
            a = int'(ratio_q8);
            b = int'(lim_v_hi);
            case ($urandom_range(0, 3))
                0: it.exhaled_volume = clip_v(near(b * 10, 20));
                1: it.exhaled_volume = clip_v(near(a * b * 10 / 256, 20));
                2: it.exhaled_volume = clip_v(near(int'(lim_v_lo) * 10, 20));
                default: ;
            endcase
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: predict on acceptance, then send the next pending item
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                alarm_due.push_back(advance_alarms(on_wire));
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (item_backlog.size() != 0)
                begin
                    on_wire = item_backlog.pop_front();
                    cmd              <= on_wire.cmd;
                    now_ms           <= on_wire.now_ms;
                    expiring         <= on_wire.expiring;
                    airway_pressure  <= on_wire.airway_pressure;
                    breath_seq       <= on_wire.breath_seq;
                    breath_complete  <= on_wire.breath_complete;
                    peak_valid       <= on_wire.peak_valid;
                    plateau_valid    <= on_wire.plateau_valid;
                    volume_valid     <= on_wire.volume_valid;
                    peak_pressure    <= on_wire.peak_pressure;
                    plateau_pressure <= on_wire.plateau_pressure;
                    exhaled_volume   <= on_wire.exhaled_volume;
                    in_valid         <= 1'b1;
                    send_gap = pick_gap(quiet_send);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        alarm_vec_t got;
        alarm_vec_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {high_pressure_alarm, low_pressure_alarm,
                       high_volume_alarm, low_volume_alarm};
                if (alarm_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %b", $time, got);
                    errors++;
                end
                else
                begin
                    want = alarm_due.pop_front();
                    for (int i = 0; i < 4; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            $display("%0t: %s mismatch, expected %b, actual %b",
                                     $time, alarm_name[i], want[i], got[i]);
                            errors++;
                        end
                    end
                end
                recv_gap = pick_gap(quiet_recv);
            end
            if (recv_gap != 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    task automatic wait_idle();
        do @(negedge clk);
        while (item_backlog.size() != 0 || in_valid || alarm_due.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input int val);
        logic [CFG_DATA_W-1:0] data;
        data = val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_register(idx, data);
    endtask

    task automatic set_limits(input int p_hi, input int p_lo, input int v_hi,
                              input int v_lo, input int conf, input int lpb,
                              input int vcb, input int rq);
        write_register(CFG_PRESSURE_HIGH_LIMIT, p_hi);
        write_register(CFG_PRESSURE_LOW_LIMIT, p_lo);
        write_register(CFG_VOLUME_HIGH_LIMIT, v_hi);
        write_register(CFG_VOLUME_LOW_LIMIT, v_lo);
        write_register(CFG_HIGH_PRESSURE_CONFIRM_MS, conf);
        write_register(CFG_LOW_PRESSURE_BREATHS, lpb);
        write_register(CFG_VOLUME_CONFIRM_BREATHS, vcb);
        write_register(CFG_IMMEDIATE_RATIO_Q8, rq);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            item_backlog.push_back(random_item());
        wait_idle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset limits: confirm timing, hold, expiration clear, time wrap
        item_backlog.push_back(make_sample(32'd1000, 1'b0, 401));
        item_backlog.push_back(make_sample(32'd1099, 1'b0, 2047));
        item_backlog.push_back(make_sample(32'd1100, 1'b0, 401));
        item_backlog.push_back(make_sample(32'd1200, 1'b0, 400));
        item_backlog.push_back(make_sample(32'd1300, 1'b0, -2048));
        item_backlog.push_back(make_sample(32'd1301, 1'b1, 2047));
        item_backlog.push_back(make_sample(32'hFFFF_FFC0, 1'b0, 500));
        item_backlog.push_back(make_sample(32'h0000_0030, 1'b0, 500));
        item_backlog.push_back(make_sample(32'hFFFF_FFFF, 1'b1, 0));
        // First breath, incomplete and repeated breaths
        item_backlog.push_back(make_breath(32'd0, 1, 1, 1, 1, 40, 60, 5000));
        item_backlog.push_back(make_breath(32'd1, 0, 1, 1, 1, 0, 0, 0));
        item_backlog.push_back(make_breath(32'd0, 1, 1, 1, 1, -2048, -2048, 0));
        // Counting up low pressure and high volume, with an equal value between
        item_backlog.push_back(make_breath(32'd1, 1, 1, 1, 1, 49, 50, 10500));
        item_backlog.push_back(make_breath(32'd2, 1, 1, 1, 1, 50, 50, 10000));
        item_backlog.push_back(make_breath(32'd3, 1, 1, 0, 1, -2048, 2047, 10500));
        item_backlog.push_back(make_breath(32'd4, 1, 1, 0, 1, 0, 0, 10500));
        item_backlog.push_back(make_breath(32'd5, 1, 1, 0, 1, -1, 0, 10500));
        // Equal to limit while active: counts drop, alarms stay
        item_backlog.push_back(make_breath(32'd6, 1, 1, 1, 1, 50, 50, 10000));
        // Recovery on plateau wins over a low peak; volume not valid
        item_backlog.push_back(make_breath(32'd7, 1, 1, 1, 0, 10, 51, 65535));
        // Immediate high volume, then below the high limit, then equal to the low limit
        item_backlog.push_back(make_breath(32'd8, 1, 1, 1, 1, 60, 60, 20000));
        item_backlog.push_back(make_breath(32'd9, 1, 1, 1, 1, 60, 60, 9999));
        item_backlog.push_back(make_breath(32'hFFFF_FFFF, 1, 0, 0, 1, 0, 0, 2000));
        // Leave low pressure and low volume counts at two, alarms off
        item_backlog.push_back(make_breath(32'd10, 1, 1, 1, 1, 30, 30, 1999));
        item_backlog.push_back(make_breath(32'd11, 1, 1, 1, 1, 30, 30, 0));
        wait_idle();

        // Lowered thresholds below the running counts
        write_register(CFG_LOW_PRESSURE_BREATHS, 1);
        write_register(CFG_VOLUME_CONFIRM_BREATHS, 1);
        item_backlog.push_back(make_breath(32'd12, 1, 1, 1, 1, 30, 30, 100));
        wait_idle();
        gen_ms  = 32'd5000;
        gen_seq = 32'd100;
        run_random(60);

        // All registers at their lowest: zero confirm time, zero breath counts
        set_limits(0, 0, 0, 0, 0, 0, 0, 0);
        item_backlog.push_back(make_sample(32'd5, 1'b0, 1));
        item_backlog.push_back(make_sample(32'd5, 1'b0, 1));
        item_backlog.push_back(make_breath(32'd200, 1, 1, 1, 1, -5, -5, 1));
        wait_idle();
        quiet_send = 1'b1;
        quiet_recv = 1'b1;
        run_random(90);

        // All registers at their highest
        set_limits(2047, 2047, 4095, 4095, 65535, 15, 15, 1023);
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
        run_random(90);

        // Random settings, one with an immediate ratio below one
        for (int k = 0; k < 4; k++)
        begin
            set_limits($urandom_range(0, 1200), $urandom_range(0, 1200),
                       $urandom_range(0, 4000), $urandom_range(0, 4000),
                       (k == 3) ? $urandom_range(0, 65535) : $urandom_range(0, 400),
                       $urandom_range(1, 5), $urandom_range(1, 5),
                       (k == 1) ? $urandom_range(0, 255) : $urandom_range(256, 1023));
            quiet_send = (k == 2);
            quiet_recv = (k == 0);
            run_random(100);
        end

        // Drain: let any stray result show up
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
